// ===== rtl/core/tpba_pkg.sv =====
`default_nettype none
package tpba_pkg;

  localparam int ADDR_W = 11;
  localparam int SIZE_W = 16;
  // wide enough for the arena end at the largest parameter values
  localparam int FULL_ADDR_W = 20;

  localparam int SMALL_BLOCKS_DEF       = 5;
  localparam int SMALL_BLOCK_BYTES_DEF  = 16;
  localparam int MEDIUM_BLOCKS_DEF      = 10;
  localparam int MEDIUM_BLOCK_BYTES_DEF = 64;
  localparam int LARGE_BLOCKS_DEF       = 5;
  localparam int LARGE_BLOCK_BYTES_DEF  = 128;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CLASS_SMALL  = 2'd0,
    CLASS_MEDIUM = 2'd1,
    CLASS_LARGE  = 2'd2,
    CLASS_NONE   = 2'd3
  } pool_class_t;

  typedef struct packed {
    logic alloc;
    logic free;
  } pool_cmd_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] grant_addr;
    logic              hit;
  } pool_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/tpba_if.sv =====
`default_nettype none
interface tpba_in_if;
  logic                           valid;
  logic                           ready;
  tpba_pkg::op_t                  op;
  logic [tpba_pkg::SIZE_W-1:0]    request_bytes;
  logic [tpba_pkg::ADDR_W-1:0]    block_address;

  modport source (output valid, output op, output request_bytes, output block_address,
                  input ready);
  modport sink (input valid, input op, input request_bytes, input block_address,
                output ready);
endinterface

interface tpba_out_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [tpba_pkg::ADDR_W-1:0] granted_address;
  tpba_pkg::pool_class_t       pool_class;

  modport source (output valid, output success, output granted_address, output pool_class,
                  input ready);
  modport sink (input valid, input success, input granted_address, input pool_class,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tpba_pool.sv =====
`default_nettype none
module tpba_pool #(
  parameter int BLOCKS      = tpba_pkg::SMALL_BLOCKS_DEF,
  parameter int BLOCK_BYTES = tpba_pkg::SMALL_BLOCK_BYTES_DEF,
  parameter int BASE        = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tpba_pkg::pool_cmd_t         cmd,
  input  wire logic [tpba_pkg::ADDR_W-1:0] addr,
  output tpba_pkg::pool_stat_t             stat
);

  localparam int FW = tpba_pkg::FULL_ADDR_W;

  logic [BLOCKS-1:0]           used_r;
  logic [BLOCKS-1:0]           used_nxt;
  logic [BLOCKS-1:0]           free_vec;
  logic [BLOCKS-1:0]           pick;
  logic [BLOCKS-1:0]           slot_hit;
  logic [tpba_pkg::ADDR_W-1:0] slot_addr [BLOCKS];
  logic [tpba_pkg::ADDR_W-1:0] grant;
  logic [FW-1:0]               addr_w;

  assign addr_w = FW'(addr);

  // per-slot address window, all bounds fixed at elaboration
  for (genvar i = 0; i < BLOCKS; i++) begin : g_slot
    localparam int LO = BASE + i * BLOCK_BYTES;
    localparam int HI = LO + BLOCK_BYTES;
    assign slot_hit[i]  = (addr_w >= FW'(LO)) && (addr_w < FW'(HI));
    assign slot_addr[i] = tpba_pkg::ADDR_W'(LO);
  end

  // lowest free block as a one-hot vector
  assign free_vec = ~used_r;
  assign pick     = free_vec & (~free_vec + BLOCKS'(1));

  always_comb begin
    grant = '0;
    for (int i = 0; i < BLOCKS; i++) begin
      if (pick[i]) begin
        grant = grant | slot_addr[i];
      end
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (cmd.alloc) begin
      used_nxt = used_nxt | pick;
    end
    if (cmd.free) begin
      used_nxt = used_nxt & ~slot_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign stat.found      = |free_vec;
  assign stat.grant_addr = grant;
  assign stat.hit        = |slot_hit;

endmodule
`default_nettype wire

// ===== rtl/core/three_pool_block_allocator.sv =====
// Fixed-size block allocator over three pools laid out back to back from address 0
// (small, medium, large blocks). An allocate request takes the lowest free block of the
// smallest class whose block size holds the requested bytes and returns its address;
// a release request frees the block that contains the given address. One request is
// accepted every clock cycle while in_ch.ready is high; an accepted request is held in the
// input register until the result register is free, then moves into the result register,
// where it is held until it is taken. The pool bitmaps are updated as a request moves into
// the result register, so the next request already sees its effect. A held result only
// stalls the input once the input register is full.
`default_nettype none
module three_pool_block_allocator #(
  parameter int SMALL_BLOCKS       = tpba_pkg::SMALL_BLOCKS_DEF,
  parameter int SMALL_BLOCK_BYTES  = tpba_pkg::SMALL_BLOCK_BYTES_DEF,
  parameter int MEDIUM_BLOCKS      = tpba_pkg::MEDIUM_BLOCKS_DEF,
  parameter int MEDIUM_BLOCK_BYTES = tpba_pkg::MEDIUM_BLOCK_BYTES_DEF,
  parameter int LARGE_BLOCKS       = tpba_pkg::LARGE_BLOCKS_DEF,
  parameter int LARGE_BLOCK_BYTES  = tpba_pkg::LARGE_BLOCK_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tpba_in_if.sink    in_ch,
  tpba_out_if.source out_ch
);

  localparam int MEDIUM_BASE = SMALL_BLOCKS * SMALL_BLOCK_BYTES;
  localparam int LARGE_BASE  = MEDIUM_BASE + MEDIUM_BLOCKS * MEDIUM_BLOCK_BYTES;
  localparam int SW          = tpba_pkg::SIZE_W;
  localparam int AW          = tpba_pkg::ADDR_W;

  // input register
  logic                  s1_valid_r;
  tpba_pkg::op_t         s1_op_r;
  logic [SW-1:0]         s1_bytes_r;
  logic [AW-1:0]         s1_addr_r;

  // result register
  logic                  out_valid_r;
  logic                  success_r;
  logic [AW-1:0]         granted_r;
  tpba_pkg::pool_class_t class_r;

  logic                  success_nxt;
  logic [AW-1:0]         granted_nxt;
  tpba_pkg::pool_class_t class_nxt;

  logic                  out_free;
  logic                  s1_adv;
  logic                  in_take;
  tpba_pkg::pool_class_t sel_class;

  tpba_pkg::pool_cmd_t   small_cmd, medium_cmd, large_cmd;
  tpba_pkg::pool_stat_t  small_stat, medium_stat, large_stat;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_take      = in_ch.valid && in_ch.ready;

  // smallest class that holds the request, no fallback to a larger pool
  always_comb begin
    sel_class = tpba_pkg::CLASS_NONE;
    if (s1_bytes_r != '0) begin
      if (s1_bytes_r <= SW'(SMALL_BLOCK_BYTES)) begin
        sel_class = tpba_pkg::CLASS_SMALL;
      end else if (s1_bytes_r <= SW'(MEDIUM_BLOCK_BYTES)) begin
        sel_class = tpba_pkg::CLASS_MEDIUM;
      end else if (s1_bytes_r <= SW'(LARGE_BLOCK_BYTES)) begin
        sel_class = tpba_pkg::CLASS_LARGE;
      end
    end
  end

  always_comb begin
    small_cmd.alloc  = s1_adv && (s1_op_r == tpba_pkg::OP_ALLOC) &&
                       (sel_class == tpba_pkg::CLASS_SMALL);
    medium_cmd.alloc = s1_adv && (s1_op_r == tpba_pkg::OP_ALLOC) &&
                       (sel_class == tpba_pkg::CLASS_MEDIUM);
    large_cmd.alloc  = s1_adv && (s1_op_r == tpba_pkg::OP_ALLOC) &&
                       (sel_class == tpba_pkg::CLASS_LARGE);
    small_cmd.free   = s1_adv && (s1_op_r == tpba_pkg::OP_FREE);
    medium_cmd.free  = small_cmd.free;
    large_cmd.free   = small_cmd.free;
  end

  tpba_pool #(
    .BLOCKS(SMALL_BLOCKS), .BLOCK_BYTES(SMALL_BLOCK_BYTES), .BASE(0)
  ) u_small (
    .clk(clk), .rst_n(rst_n), .cmd(small_cmd), .addr(s1_addr_r), .stat(small_stat)
  );

  tpba_pool #(
    .BLOCKS(MEDIUM_BLOCKS), .BLOCK_BYTES(MEDIUM_BLOCK_BYTES), .BASE(MEDIUM_BASE)
  ) u_medium (
    .clk(clk), .rst_n(rst_n), .cmd(medium_cmd), .addr(s1_addr_r), .stat(medium_stat)
  );

  tpba_pool #(
    .BLOCKS(LARGE_BLOCKS), .BLOCK_BYTES(LARGE_BLOCK_BYTES), .BASE(LARGE_BASE)
  ) u_large (
    .clk(clk), .rst_n(rst_n), .cmd(large_cmd), .addr(s1_addr_r), .stat(large_stat)
  );

  always_comb begin
    success_nxt = 1'b0;
    granted_nxt = '0;
    class_nxt   = tpba_pkg::CLASS_NONE;
    if (s1_op_r == tpba_pkg::OP_ALLOC) begin
      unique case (sel_class)
        tpba_pkg::CLASS_SMALL: begin
          if (small_stat.found) begin
            success_nxt = 1'b1;
            granted_nxt = small_stat.grant_addr;
            class_nxt   = tpba_pkg::CLASS_SMALL;
          end
        end
        tpba_pkg::CLASS_MEDIUM: begin
          if (medium_stat.found) begin
            success_nxt = 1'b1;
            granted_nxt = medium_stat.grant_addr;
            class_nxt   = tpba_pkg::CLASS_MEDIUM;
          end
        end
        tpba_pkg::CLASS_LARGE: begin
          if (large_stat.found) begin
            success_nxt = 1'b1;
            granted_nxt = large_stat.grant_addr;
            class_nxt   = tpba_pkg::CLASS_LARGE;
          end
        end
        default: begin
        end
      endcase
    end else begin
      // pool ranges are disjoint, so at most one hit
      if (small_stat.hit) begin
        success_nxt = 1'b1;
        class_nxt   = tpba_pkg::CLASS_SMALL;
      end else if (medium_stat.hit) begin
        success_nxt = 1'b1;
        class_nxt   = tpba_pkg::CLASS_MEDIUM;
      end else if (large_stat.hit) begin
        success_nxt = 1'b1;
        class_nxt   = tpba_pkg::CLASS_LARGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= in_ch.op;
      s1_bytes_r <= in_ch.request_bytes;
      s1_addr_r  <= in_ch.block_address;
    end
    if (s1_adv) begin
      success_r <= success_nxt;
      granted_r <= granted_nxt;
      class_r   <= class_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.success         = success_r;
  assign out_ch.granted_address = granted_r;
  assign out_ch.pool_class      = class_r;

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !success_r |-> (class_r == tpba_pkg::CLASS_NONE) && (granted_r == '0))
    else $error("failed request carries a pool or an address");

  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0({small_stat.hit, medium_stat.hit, large_stat.hit}))
    else $error("release address decoded into more than one pool");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("request left the input register without a result");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while both registers are held");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
import tpba_pkg::*;

typedef struct {
  logic              success;
  logic [ADDR_W-1:0] granted_address;
  pool_class_t       pool_class;
} grant_t;

class alloc_scoreboard;
  logic [31:0] pool_used[3];
  int unsigned block_count[3];
  int unsigned block_bytes[3];
  int unsigned pool_base[3];
  grant_t      expected_q[$];
  int unsigned mismatches;

  function new();
    block_count = '{SMALL_BLOCKS_DEF, MEDIUM_BLOCKS_DEF, LARGE_BLOCKS_DEF};
    block_bytes = '{SMALL_BLOCK_BYTES_DEF, MEDIUM_BLOCK_BYTES_DEF, LARGE_BLOCK_BYTES_DEF};
    pool_base[0] = 0;
    pool_base[1] = SMALL_BLOCKS_DEF * SMALL_BLOCK_BYTES_DEF;
    pool_base[2] = pool_base[1] + MEDIUM_BLOCKS_DEF * MEDIUM_BLOCK_BYTES_DEF;
    foreach (pool_used[k]) pool_used[k] = '0;
    mismatches = 0;
  endfunction

  // updates the pool bitmaps for one accepted request and queues its grant
  function void note_request(op_t op, logic [SIZE_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
    grant_t g;
    int     pick;
    int     slot;
    int     k;
    g.success         = 1'b0;
    g.granted_address = '0;
    g.pool_class      = CLASS_NONE;
    pick = -1;
    slot = -1;
    if (op == OP_ALLOC) begin
      // smallest class that holds the size, no fallback when it is full
      for (k = 2; k >= 0; k--)
        if (nbytes != 0 && nbytes <= block_bytes[k]) pick = k;
      if (pick >= 0) begin
        for (k = int'(block_count[pick]) - 1; k >= 0; k--)
          if (!pool_used[pick][k]) slot = k;
        if (slot >= 0) begin
          pool_used[pick][slot] = 1'b1;
          g.success         = 1'b1;
          g.granted_address = ADDR_W'(pool_base[pick] + slot * block_bytes[pick]);
          g.pool_class      = pool_class_t'(pick);
        end
      end
    end else begin
      for (k = 0; k < 3 && pick < 0; k++)
        if (addr >= pool_base[k] && addr < pool_base[k] + block_count[k] * block_bytes[k])
          pick = k;
      if (pick >= 0) begin
        pool_used[pick][(addr - pool_base[pick]) / block_bytes[pick]] = 1'b0;
        g.success    = 1'b1;
        g.pool_class = pool_class_t'(pick);
      end
    end
    expected_q.push_back(g);
  endfunction

  function void check_grant(logic success, logic [ADDR_W-1:0] granted, pool_class_t cls);
    grant_t g;
    if (expected_q.size() == 0) begin
      $error("result with no request pending: success %0b address %0d class %0d",
             success, granted, cls);
      mismatches++;
      return;
    end
    g = expected_q.pop_front();
    if (success !== g.success) begin
      $error("success: expected %0b, actual %0b", g.success, success);
      mismatches++;
    end
    if (granted !== g.granted_address) begin
      $error("granted_address: expected %0d, actual %0d", g.granted_address, granted);
      mismatches++;
    end
    if (cls !== g.pool_class) begin
      $error("pool_class: expected %0d, actual %0d", g.pool_class, cls);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES  = 2000;
  localparam int RANDOM_PER_PHASE = 420;
  localparam int HOLD_CYCLES      = 80;
  localparam int DRAIN_CYCLES     = 10;

  typedef enum int {
    PH_DIRECTED,
    PH_FREE_RUN,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH
  } phase_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  phase_t          phase = PH_DIRECTED;
  int              quiet_cycles = 0;
  alloc_scoreboard sb;

  tpba_in_if  in_ch ();
  tpba_out_if out_ch ();

  three_pool_block_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send(op_t op, logic [SIZE_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
    int idle_pct;
    idle_pct = (phase == PH_SENDER_IDLE) ? 76 : (phase == PH_BOTH) ? 20 : 0;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.request_bytes <= nbytes;
    in_ch.block_address <= addr;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, nbytes, addr);
  endtask

  initial begin : receiver
    int  hold_left;
    int  stall_pct;
    bit  held_once;
    hold_left = 0;
    held_once = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      // one long hold-off while the sender keeps pushing, so the pipe backs up
      if (!held_once && phase == PH_FREE_RUN) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      stall_pct = (phase == PH_RECEIVER_STALL) ? 76 : (phase == PH_BOTH) ? 20 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_grant(out_ch.success, out_ch.granted_address, out_ch.pool_class);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_CYCLES) begin
        $display("** three_pool_block_allocator: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int              p;
    int              n;
    int              k;
    int              s;
    int              roll;
    int unsigned     arena_end;
    logic [SIZE_W-1:0] nbytes;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] live_q[$];
    sb = new();
    arena_end = sb.pool_base[2] + sb.block_count[2] * sb.block_bytes[2];
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.block_address = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // size boundaries of each class, zero size and oversize
    send(OP_ALLOC, 16'd0, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd1, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd16, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd17, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd64, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd65, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd128, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd129, ADDR_W'($urandom));
    send(OP_ALLOC, 16'hFFFF, ADDR_W'($urandom));
    // fill the small pool, then one more must fail without falling back
    send(OP_ALLOC, 16'd8, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd12, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd16, ADDR_W'($urandom));
    send(OP_ALLOC, 16'd3, ADDR_W'($urandom));
    // release from inside a block, release it again, then reuse it
    send(OP_FREE, SIZE_W'($urandom), 11'd5);
    send(OP_FREE, SIZE_W'($urandom), 11'd5);
    send(OP_ALLOC, 16'd10, ADDR_W'($urandom));
    // pool edges and addresses past the arena
    send(OP_FREE, SIZE_W'($urandom), 11'd79);
    send(OP_FREE, SIZE_W'($urandom), 11'd80);
    send(OP_FREE, SIZE_W'($urandom), 11'd719);
    send(OP_FREE, SIZE_W'($urandom), 11'd720);
    send(OP_FREE, SIZE_W'($urandom), ADDR_W'(arena_end - 1));
    send(OP_FREE, SIZE_W'($urandom), ADDR_W'(arena_end));
    send(OP_FREE, SIZE_W'($urandom), 11'd2047);

    for (p = PH_FREE_RUN; p <= PH_BOTH; p++) begin
      phase = phase_t'(p);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if ($urandom_range(99) < 52) begin
          if (roll < 30)      nbytes = SIZE_W'($urandom_range(16, 1));
          else if (roll < 55) nbytes = SIZE_W'($urandom_range(64, 17));
          else if (roll < 80) nbytes = SIZE_W'($urandom_range(128, 65));
          else if (roll < 85) nbytes = '0;
          else if (roll < 92) nbytes = SIZE_W'($urandom_range(65535, 129));
          else                nbytes = SIZE_W'($urandom);
          send(OP_ALLOC, nbytes, ADDR_W'($urandom));
        end else begin
          // mostly release a block in use, at a random offset inside it
          live_q.delete();
          for (k = 0; k < 3; k++)
            for (s = 0; s < int'(sb.block_count[k]); s++)
              if (sb.pool_used[k][s])
                live_q.push_back(ADDR_W'(sb.pool_base[k] + s * sb.block_bytes[k]
                                         + $urandom_range(sb.block_bytes[k] - 1)));
          if (roll < 75 && live_q.size() > 0) addr = live_q[$urandom_range(live_q.size() - 1)];
          else if (roll < 88)                 addr = ADDR_W'($urandom_range(arena_end - 1));
          else                                addr = ADDR_W'($urandom);
          send(OP_FREE, SIZE_W'($urandom), addr);
        end
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** three_pool_block_allocator: PASSED **");
    end else begin
      $display("** three_pool_block_allocator: FAILED **");
    end
    $finish;
  end
endmodule
